// ----- src/psq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_pkg: shared types and constants
// Entry layout, status and register codes, and controller/datapath handshake
// structs for the per-source capability quota block.
// ----------------------------------------------------------------------------
package psq_pkg;

  localparam int unsigned MAX_SOURCES_DEF = 16;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned RET_W    = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned STAMP_W  = 8;
  localparam int unsigned PKT_W    = 16;
  localparam int unsigned RTN_W    = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // status codes
  localparam logic [STATUS_W-1:0] ST_STAMPED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOROOM  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ACK_OK  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ACK_IGN = 3'd5;

  // command codes
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_ACK    = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAMP_LIMIT   = 2'd2;

  localparam logic [TICK_W-1:0]  WINDOW_LENGTH_RST = 32'd1000;
  localparam logic [TICK_W-1:0]  SEND_PERIOD_RST   = 32'd750;
  localparam logic [STAMP_W-1:0] STAMP_LIMIT_RST   = 8'd127;

  localparam logic [STAMP_W-1:0] STAMP_MAX = 8'hFF;
  localparam logic [PKT_W-1:0]   PKT_MAX   = 16'hFFFF;
  localparam logic [RTN_W-1:0]   RTN_MAX   = 10'h3FF;

  typedef struct packed {
    logic [ADDR_W-1:0]  source;
    logic [TICK_W-1:0]  start;
    logic [STAMP_W-1:0] stamps;
    logic [PKT_W-1:0]   packets;
    logic [RTN_W-1:0]   returns;
  } entry_t;

  typedef struct packed {
    logic start;   // latch a new item, restart the search
    logic search;  // walk the table one entry per cycle
    logic update;  // compute result, write entry if needed, load output
  } ctrl_cmd_t;

  typedef struct packed {
    logic found;
    logic miss;
  } dp_stat_t;

endpackage

// ----- src/psq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module psq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/psq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_ctrl: transaction sequencer
// Accepts one item, runs the table search, then issues the update once the
// output register is free.
// ----------------------------------------------------------------------------
module psq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  psq_pkg::dp_stat_t    stat_i,
  output psq_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;

  assign cmd_o.start  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.search = (state_q == S_SEARCH);
  assign cmd_o.update = (state_q == S_UPDATE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (stat_i.found || stat_i.miss) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cmd_o.update) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_update_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> out_valid_q)
    else $error("result not presented after update");

  a_search_ends_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.search && (stat_i.found || stat_i.miss)) |=> (state_q == S_UPDATE))
    else $error("search end did not lead to update");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.update)
    else $error("update overwrote a pending result");

endmodule

// ----- src/psq_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_dp: source table datapath
// Configuration registers, item registers, table RAM with a one-entry-per-cycle
// search, the entry update and the result register.
// ----------------------------------------------------------------------------
module psq_dp #(
  parameter int unsigned MaxSources = psq_pkg::MAX_SOURCES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [psq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psq_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              command_i,
  input  logic [psq_pkg::ADDR_W-1:0]        source_addr_i,
  input  logic [psq_pkg::TICK_W-1:0]        now_tick_i,
  input  logic                              room_ok_i,
  input  logic [psq_pkg::RET_W-1:0]         returned_count_i,
  input  psq_pkg::ctrl_cmd_t                cmd_i,
  output psq_pkg::dp_stat_t                 stat_o,
  output logic [psq_pkg::STATUS_W-1:0]      status_o,
  output logic [psq_pkg::STAMP_W-1:0]       capability_number_o,
  output logic [psq_pkg::PKT_W-1:0]         packets_in_window_o,
  output logic [psq_pkg::RTN_W-1:0]         returns_in_window_o
);

  localparam int unsigned CntW  = $clog2(MaxSources + 1);
  localparam int unsigned AddrW = (MaxSources > 1) ? $clog2(MaxSources) : 1;
  localparam int unsigned EntW  = $bits(psq_pkg::entry_t);

  // configuration
  logic [psq_pkg::TICK_W-1:0]  wlen_q, sper_q;
  logic [psq_pkg::STAMP_W-1:0] slim_q;

  // item registers
  logic                        cmd_q;
  logic [psq_pkg::ADDR_W-1:0]  addr_q;
  logic [psq_pkg::TICK_W-1:0]  now_q;
  logic                        room_q;
  logic [psq_pkg::RET_W-1:0]   ret_q;

  // search state
  logic [CntW-1:0]  used_q, rd_idx_q, cmp_idx_q;
  logic             cmp_vld_q;
  logic             hit_q;
  logic [AddrW-1:0] hit_idx_q;
  psq_pkg::entry_t  ent_q;

  // result register
  logic [psq_pkg::STATUS_W-1:0] res_status_q;
  logic [psq_pkg::STAMP_W-1:0]  res_stamps_q;
  logic [psq_pkg::PKT_W-1:0]    res_packets_q;
  logic [psq_pkg::RTN_W-1:0]    res_returns_q;

  // table RAM
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [EntW-1:0]  ram_rdata;
  psq_pkg::entry_t  rd_ent;
  psq_pkg::entry_t  nxt_ent;

  logic issue, found, miss;

  assign rd_ent = psq_pkg::entry_t'(ram_rdata);
  assign found  = cmd_i.search && cmp_vld_q && (rd_ent.source == addr_q);
  assign miss   = cmd_i.search && !cmp_vld_q && (rd_idx_q >= used_q);
  assign issue  = cmd_i.search && !found && (rd_idx_q < used_q);

  assign stat_o.found = found;
  assign stat_o.miss  = miss;

  psq_ram #(
    .Width (EntW),
    .Depth (MaxSources)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (nxt_ent),
    .re_i    (issue),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // update logic
  logic                         full;
  logic                         do_write;
  logic                         alloc;
  logic [psq_pkg::TICK_W-1:0]   diff;
  logic                         stale;
  logic                         in_period;
  logic [psq_pkg::RTN_W:0]      rtn_sum;
  psq_pkg::entry_t              base_ent, cur_ent;
  logic [psq_pkg::STATUS_W-1:0] upd_status;
  logic                         zero_fields;

  assign full = (used_q == CntW'(MaxSources));

  always_comb begin
    base_ent.source  = addr_q;
    base_ent.start   = now_q;
    base_ent.stamps  = '0;
    base_ent.packets = '0;
    base_ent.returns = '0;
    if (hit_q) begin
      base_ent = ent_q;
    end

    diff      = now_q - base_ent.start;
    stale     = (diff > wlen_q);
    in_period = stale || (diff <= sper_q);

    cur_ent = base_ent;
    if (stale) begin
      cur_ent.start   = now_q;
      cur_ent.stamps  = '0;
      cur_ent.packets = '0;
      cur_ent.returns = '0;
    end

    rtn_sum = {1'b0, base_ent.returns} + (psq_pkg::RTN_W + 1)'(ret_q);

    nxt_ent     = cur_ent;
    upd_status  = psq_pkg::ST_ACK_IGN;
    do_write    = 1'b0;
    alloc       = 1'b0;
    zero_fields = 1'b0;

    if (cmd_q == psq_pkg::CMD_PACKET) begin
      if (!hit_q && full) begin
        upd_status  = psq_pkg::ST_FULL;
        zero_fields = 1'b1;
      end else begin
        alloc    = !hit_q;
        do_write = 1'b1;
        if (cur_ent.packets != psq_pkg::PKT_MAX) begin
          nxt_ent.packets = cur_ent.packets + psq_pkg::PKT_W'(1);
        end
        if (in_period && (cur_ent.stamps <= slim_q)) begin
          if (room_q) begin
            if (cur_ent.stamps != psq_pkg::STAMP_MAX) begin
              nxt_ent.stamps = cur_ent.stamps + psq_pkg::STAMP_W'(1);
            end
            upd_status = psq_pkg::ST_STAMPED;
          end else begin
            upd_status = psq_pkg::ST_NOROOM;
          end
        end else begin
          upd_status = psq_pkg::ST_BLOCKED;
        end
      end
    end else begin
      // acknowledges never restart the window
      nxt_ent = base_ent;
      if (!hit_q) begin
        zero_fields = 1'b1;
      end else if ((ret_q != '0) && !stale &&
                   (base_ent.returns <= {2'b00, slim_q})) begin
        do_write   = 1'b1;
        upd_status = psq_pkg::ST_ACK_OK;
        if (rtn_sum[psq_pkg::RTN_W]) begin
          nxt_ent.returns = psq_pkg::RTN_MAX;
        end else begin
          nxt_ent.returns = rtn_sum[psq_pkg::RTN_W-1:0];
        end
      end
    end
  end

  assign ram_we    = cmd_i.update && do_write;
  assign ram_waddr = hit_q ? hit_idx_q : used_q[AddrW-1:0];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q    <= psq_pkg::WINDOW_LENGTH_RST;
      sper_q    <= psq_pkg::SEND_PERIOD_RST;
      slim_q    <= psq_pkg::STAMP_LIMIT_RST;
      used_q    <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          psq_pkg::CFG_WINDOW_LENGTH: wlen_q <= cfg_data_i;
          psq_pkg::CFG_SEND_PERIOD:   sper_q <= cfg_data_i;
          psq_pkg::CFG_STAMP_LIMIT:   slim_q <= cfg_data_i[psq_pkg::STAMP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.search) begin
        cmp_vld_q <= issue;
        if (issue) begin
          rd_idx_q <= rd_idx_q + CntW'(1);
        end
      end
      if (cmd_i.update && alloc) begin
        used_q <= used_q + CntW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q  <= command_i;
      addr_q <= source_addr_i;
      now_q  <= now_tick_i;
      room_q <= room_ok_i;
      ret_q  <= returned_count_i;
    end
    if (issue) begin
      cmp_idx_q <= rd_idx_q;
    end
    if (found) begin
      ent_q     <= rd_ent;
      hit_q     <= 1'b1;
      hit_idx_q <= cmp_idx_q[AddrW-1:0];
    end else if (miss) begin
      hit_q <= 1'b0;
    end
    if (cmd_i.update) begin
      res_status_q <= upd_status;
      if (zero_fields) begin
        res_stamps_q  <= '0;
        res_packets_q <= '0;
        res_returns_q <= '0;
      end else begin
        res_stamps_q  <= nxt_ent.stamps;
        res_packets_q <= nxt_ent.packets;
        res_returns_q <= nxt_ent.returns;
      end
    end
  end

  assign status_o            = res_status_q;
  assign capability_number_o = res_stamps_q;
  assign packets_in_window_o = res_packets_q;
  assign returns_in_window_o = res_returns_q;

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(MaxSources))
    else $error("table fill count beyond depth");

  a_match_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found |-> (cmp_idx_q < used_q))
    else $error("match on an unallocated entry");

  a_write_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cmd_i.update && !cmd_i.search && !cmd_i.start))
    else $error("table written outside update");

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> ((rd_idx_q == '0) && !cmp_vld_q))
    else $error("search not restarted");

endmodule

// ----- src/per_source_capability_quota.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_capability_quota: per-source capability stamping and quota
// Source table with window, stamp, packet and return counters per client.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction: an
//   outgoing packet (command 0) or a returned acknowledge (command 1).
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   per transaction, in order. Configuration writes (cfg_valid_i /
//   cfg_ready_o, index 0 window length, 1 send period, 2 stamp limit) are
//   always ready and must only be issued while the block is idle.
//   The table is searched one entry per cycle through the RAM read port;
//   a hit on entry k ends the search when its read data compares equal,
//   a miss when every used entry has been read and compared (an empty
//   table misses without a read). The update then loads the output
//   register and writes the entry where needed. One transaction is
//   processed at a time; the next is accepted in the cycle after the
//   update, even while the previous result is stalled.
//   A stalled result holds in the output register; the update of the next
//   transaction waits until that register is free.
//   Reset empties the table (fill count to zero) and loads the register
//   defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_source_capability_quota #(
  parameter int unsigned MAX_SOURCES = psq_pkg::MAX_SOURCES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [psq_pkg::ADDR_W-1:0]        source_addr_i,
  input  logic [psq_pkg::TICK_W-1:0]        now_tick_i,
  input  logic                              room_ok_i,
  input  logic [psq_pkg::RET_W-1:0]         returned_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [psq_pkg::STATUS_W-1:0]      status_o,
  output logic [psq_pkg::STAMP_W-1:0]       capability_number_o,
  output logic [psq_pkg::PKT_W-1:0]         packets_in_window_o,
  output logic [psq_pkg::RTN_W-1:0]         returns_in_window_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [psq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  psq_pkg::ctrl_cmd_t cmd;
  psq_pkg::dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  psq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  psq_dp #(
    .MaxSources (MAX_SOURCES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .command_i           (command_i),
    .source_addr_i       (source_addr_i),
    .now_tick_i          (now_tick_i),
    .room_ok_i           (room_ok_i),
    .returned_count_i    (returned_count_i),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .status_o            (status_o),
    .capability_number_o (capability_number_o),
    .packets_in_window_o (packets_in_window_o),
    .returns_in_window_o (returns_in_window_o)
  );

endmodule
